// File: rtl/core/mceb_pkg.sv
// ----------------------------------------------------------------------------
// mceb_pkg
// Shared types and constants of the monochrome color expansion blitter.
// ----------------------------------------------------------------------------
package mceb_pkg;

  localparam int unsigned FB_ADDR_BITS         = 22;
  localparam int unsigned BITS_PER_SOURCE_BYTE = 8;
  localparam int unsigned PIX_ADDR_W           = 22;
  localparam int unsigned CNT_W                = 16;
  localparam int unsigned POS_W                = 12;
  localparam int unsigned PITCH_W              = 13;
  localparam int unsigned COLOR_W              = 8;
  localparam int unsigned APB_DATA_W           = 32;
  localparam int unsigned PADDR_W              = 5;
  localparam int unsigned BIT_IDX_W            = $clog2(BITS_PER_SOURCE_BYTE);
  // The start address sum is formed at least as wide as the full product.
  localparam int unsigned START_SUM_W = (FB_ADDR_BITS > POS_W + PITCH_W + 1) ?
                                        FB_ADDR_BITS : POS_W + PITCH_W + 1;

  localparam logic [PITCH_W-1:0] SCREEN_WIDTH_RESET = PITCH_W'(320);
  localparam logic [COLOR_W-1:0] FG_COLOR_RESET     = COLOR_W'(255);

  typedef logic [FB_ADDR_BITS-1:0]         fb_addr_t;
  typedef logic [PIX_ADDR_W-1:0]           pix_addr_t;
  typedef logic [CNT_W-1:0]                cnt_t;
  typedef logic [CNT_W:0]                  cnt_ext_t;
  typedef logic [POS_W-1:0]                pos_t;
  typedef logic [PITCH_W-1:0]              pitch_t;
  typedef logic [COLOR_W-1:0]              color_t;
  typedef logic [BITS_PER_SOURCE_BYTE-1:0] src_byte_t;
  typedef logic [BIT_IDX_W-1:0]            bit_idx_t;
  typedef logic [START_SUM_W-1:0]          start_sum_t;
  typedef logic [APB_DATA_W-1:0]           apb_data_t;

  typedef enum logic [2:0] {
    REG_DEST_X       = 3'd0,
    REG_DEST_Y       = 3'd1,
    REG_SCREEN_WIDTH = 3'd2,
    REG_PIX_WIDTH    = 3'd3,
    REG_PIX_HEIGHT   = 3'd4,
    REG_FG_COLOR     = 3'd5,
    REG_BG_COLOR     = 3'd6
  } reg_idx_e;

  // Settings that the expansion datapath reads from the register file.
  typedef struct packed {
    cnt_t     pix_width;
    cnt_t     pix_height;
    pitch_t   screen_width;
    color_t   fg_color;
    color_t   bg_color;
    fb_addr_t start_addr;
  } cfg_t;

endpackage

// File: rtl/core/mceb_regs.sv
// ----------------------------------------------------------------------------
// mceb_regs
// APB register file, plus the registered start address of the rectangle.
// ----------------------------------------------------------------------------
module mceb_regs (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [mceb_pkg::PADDR_W-1:0]        paddr,
  input  mceb_pkg::apb_data_t                 pwdata,
  output mceb_pkg::apb_data_t                 prdata,
  output logic                                pready,
  output mceb_pkg::cfg_t                      cfg_o
);

  mceb_pkg::pos_t       dest_x_q, dest_y_q;
  mceb_pkg::pitch_t     screen_width_q;
  mceb_pkg::cnt_t       pix_width_q, pix_height_q;
  mceb_pkg::color_t     fg_color_q, bg_color_q;
  mceb_pkg::fb_addr_t   start_addr_q;
  mceb_pkg::start_sum_t start_sum;
  mceb_pkg::reg_idx_e   reg_idx;
  logic                 wr_en;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = mceb_pkg::reg_idx_e'(paddr[mceb_pkg::PADDR_W-1:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dest_x_q       <= '0;
      dest_y_q       <= '0;
      screen_width_q <= mceb_pkg::SCREEN_WIDTH_RESET;
      pix_width_q    <= '0;
      pix_height_q   <= '0;
      fg_color_q     <= mceb_pkg::FG_COLOR_RESET;
      bg_color_q     <= '0;
    end else if (wr_en) begin
      unique case (reg_idx)
        mceb_pkg::REG_DEST_X:       dest_x_q       <= pwdata[mceb_pkg::POS_W-1:0];
        mceb_pkg::REG_DEST_Y:       dest_y_q       <= pwdata[mceb_pkg::POS_W-1:0];
        mceb_pkg::REG_SCREEN_WIDTH: screen_width_q <= pwdata[mceb_pkg::PITCH_W-1:0];
        mceb_pkg::REG_PIX_WIDTH:    pix_width_q    <= pwdata[mceb_pkg::CNT_W-1:0];
        mceb_pkg::REG_PIX_HEIGHT:   pix_height_q   <= pwdata[mceb_pkg::CNT_W-1:0];
        mceb_pkg::REG_FG_COLOR:     fg_color_q     <= pwdata[mceb_pkg::COLOR_W-1:0];
        mceb_pkg::REG_BG_COLOR:     bg_color_q     <= pwdata[mceb_pkg::COLOR_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      mceb_pkg::REG_DEST_X:       prdata = mceb_pkg::apb_data_t'(dest_x_q);
      mceb_pkg::REG_DEST_Y:       prdata = mceb_pkg::apb_data_t'(dest_y_q);
      mceb_pkg::REG_SCREEN_WIDTH: prdata = mceb_pkg::apb_data_t'(screen_width_q);
      mceb_pkg::REG_PIX_WIDTH:    prdata = mceb_pkg::apb_data_t'(pix_width_q);
      mceb_pkg::REG_PIX_HEIGHT:   prdata = mceb_pkg::apb_data_t'(pix_height_q);
      mceb_pkg::REG_FG_COLOR:     prdata = mceb_pkg::apb_data_t'(fg_color_q);
      mceb_pkg::REG_BG_COLOR:     prdata = mceb_pkg::apb_data_t'(bg_color_q);
      default:                    prdata = '0;
    endcase
  end

  // The address of the top left pixel wraps to the framebuffer address space.
  assign start_sum = mceb_pkg::start_sum_t'(dest_y_q) * mceb_pkg::start_sum_t'(screen_width_q)
                   + mceb_pkg::start_sum_t'(dest_x_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_addr_q <= '0;
    end else begin
      start_addr_q <= start_sum[mceb_pkg::FB_ADDR_BITS-1:0];
    end
  end

  assign cfg_o.pix_width    = pix_width_q;
  assign cfg_o.pix_height   = pix_height_q;
  assign cfg_o.screen_width = screen_width_q;
  assign cfg_o.fg_color     = fg_color_q;
  assign cfg_o.bg_color     = bg_color_q;
  assign cfg_o.start_addr   = start_addr_q;

endmodule

// File: rtl/core/mceb_expand.sv
// ----------------------------------------------------------------------------
// mceb_expand
// Source byte register, pixel counters and the registered pixel write output.
// ----------------------------------------------------------------------------
module mceb_expand (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  mceb_pkg::cfg_t          cfg_i,
  input  logic                    src_valid_i,
  output logic                    src_ready_o,
  input  mceb_pkg::src_byte_t     src_byte_i,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output mceb_pkg::pix_addr_t     pixel_addr_o,
  output mceb_pkg::color_t        pixel_color_o,
  output logic                    last_of_byte_o,
  output logic                    last_of_pixmap_o
);

  // Source byte register; the byte shifts left so the current pixel is the top bit.
  mceb_pkg::src_byte_t shift_q;
  logic                byte_vld_q;
  mceb_pkg::bit_idx_t  bit_idx_q;

  mceb_pkg::cnt_t      col_q, row_q;
  mceb_pkg::fb_addr_t  base_q;

  logic                out_vld_q;
  mceb_pkg::pix_addr_t addr_q;
  mceb_pkg::color_t    color_q;
  logic                byte_last_q, pix_last_q;

  logic                empty, first, restart, reload;
  mceb_pkg::cnt_t      col_eff, row_eff, col_next, row_next;
  mceb_pkg::cnt_ext_t  col_inc, row_inc;
  mceb_pkg::fb_addr_t  base_eff, base_next, addr;
  logic                row_end, pix_end, byte_last;
  logic                out_free, emit, drop, byte_done, src_acc;

  always_comb begin
    empty   = (cfg_i.pix_width == '0) || (cfg_i.pix_height == '0);
    first   = (bit_idx_q == '0);
    // A geometry shrunk under a running pixmap starts a new one.
    restart = first && ((col_q >= cfg_i.pix_width) || (row_q >= cfg_i.pix_height));
    col_eff = restart ? '0 : col_q;
    row_eff = restart ? '0 : row_q;
    reload  = first && (col_eff == '0) && (row_eff == '0);
    base_eff = reload ? cfg_i.start_addr : base_q;
    addr    = base_eff + mceb_pkg::fb_addr_t'(col_eff);

    col_inc = {1'b0, col_eff} + 1'b1;
    row_inc = {1'b0, row_eff} + 1'b1;
    row_end = (col_inc >= {1'b0, cfg_i.pix_width});
    pix_end = row_end && (row_inc >= {1'b0, cfg_i.pix_height});
    col_next  = row_end ? '0 : col_inc[mceb_pkg::CNT_W-1:0];
    row_next  = row_end ? (pix_end ? '0 : row_inc[mceb_pkg::CNT_W-1:0]) : row_eff;
    base_next = row_end ? base_eff + mceb_pkg::fb_addr_t'(cfg_i.screen_width) : base_eff;
    byte_last = row_end ||
                (bit_idx_q == mceb_pkg::bit_idx_t'(mceb_pkg::BITS_PER_SOURCE_BYTE - 1));
  end

  assign out_free    = !out_vld_q || out_ready_i;
  assign emit        = byte_vld_q && !empty && out_free;
  assign drop        = byte_vld_q && empty;
  assign byte_done   = drop || (emit && byte_last);
  assign src_ready_o = !byte_vld_q || byte_done;
  assign src_acc     = src_valid_i && src_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_vld_q <= 1'b0;
      bit_idx_q  <= '0;
    end else if (src_acc) begin
      byte_vld_q <= 1'b1;
      bit_idx_q  <= '0;
    end else if (byte_done) begin
      byte_vld_q <= 1'b0;
      bit_idx_q  <= '0;
    end else if (emit) begin
      bit_idx_q  <= bit_idx_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (src_acc) begin
      shift_q <= src_byte_i;
    end else if (emit) begin
      shift_q <= shift_q << 1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q  <= '0;
      row_q  <= '0;
      base_q <= '0;
    end else if (drop) begin
      col_q  <= '0;
      row_q  <= '0;
    end else if (emit) begin
      col_q  <= col_next;
      row_q  <= row_next;
      base_q <= base_next;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (emit) begin
      out_vld_q <= 1'b1;
    end else if (out_ready_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      addr_q      <= mceb_pkg::pix_addr_t'(addr);
      color_q     <= shift_q[mceb_pkg::BITS_PER_SOURCE_BYTE-1] ? cfg_i.fg_color
                                                               : cfg_i.bg_color;
      byte_last_q <= byte_last;
      pix_last_q  <= pix_end;
    end
  end

  assign out_valid_o      = out_vld_q;
  assign pixel_addr_o     = addr_q;
  assign pixel_color_o    = color_q;
  assign last_of_byte_o   = byte_last_q;
  assign last_of_pixmap_o = pix_last_q;

endmodule

// File: rtl/core/mono_color_expand_blit.sv
// ----------------------------------------------------------------------------
// mono_color_expand_blit
// Expands a 1-bit-per-pixel pixmap into 8-bit framebuffer pixel writes.
// ----------------------------------------------------------------------------
// Each source word is one pixmap byte, leftmost pixel in bit 7, rows padded
// to whole bytes. A byte turns into min(8, pixels left in the row) pixel
// writes, one per clock cycle while the sink is ready. The next byte is
// taken in the same cycle as the last write of the current one, so a stream
// of full bytes keeps the output busy every cycle while the sink is ready.
// A byte that arrives while the pixmap width or height is zero gives no
// writes and is dropped in the cycle after it is taken. Writes go to
// (dest_y + row) * screen_width + dest_x + column, wrapping in the 22-bit
// framebuffer address space. Registers sit at byte address 4 * index; the
// rectangle origin is sampled when a pixmap starts, from a start address
// that is registered from the origin and pitch registers.
// ----------------------------------------------------------------------------
module mono_color_expand_blit (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [mceb_pkg::PADDR_W-1:0] paddr,
  input  mceb_pkg::apb_data_t          pwdata,
  output mceb_pkg::apb_data_t          prdata,
  output logic                         pready,
  input  logic                         src_valid_i,
  output logic                         src_ready_o,
  input  mceb_pkg::src_byte_t          src_byte_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output mceb_pkg::pix_addr_t          pixel_addr_o,
  output mceb_pkg::color_t             pixel_color_o,
  output logic                         last_of_byte_o,
  output logic                         last_of_pixmap_o
);

  mceb_pkg::cfg_t cfg;

  mceb_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  mceb_expand u_expand (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_i            (cfg),
    .src_valid_i      (src_valid_i),
    .src_ready_o      (src_ready_o),
    .src_byte_i       (src_byte_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .pixel_addr_o     (pixel_addr_o),
    .pixel_color_o    (pixel_color_o),
    .last_of_byte_o   (last_of_byte_o),
    .last_of_pixmap_o (last_of_pixmap_o)
  );

endmodule

// File: verif/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the monochrome color expansion blitter. Source
// bytes go in over a valid/ready channel with random gaps. Registers are
// programmed over APB between phases. A behavioral copy of the expansion
// logic predicts every pixel write, and a checker compares each accepted
// write with the oldest prediction while the sink stalls at random.
// ----------------------------------------------------------------------------
module testbench;
  import mceb_pkg::*;

  localparam int unsigned     CLK_PERIOD    = 12;
  localparam int unsigned     SETTLE_CYCLES = 20;
  localparam int unsigned     RANDOM_BYTES  = 440;
  localparam longint unsigned RUN_LIMIT_NS  = 64'd15_000_000;

  typedef struct {
    pix_addr_t addr;
    color_t    color;
    logic      last_byte;
    logic      last_pixmap;
  } pixel_write_t;

  typedef src_byte_t byte_q_t[$];

  logic                clk_i       = 1'b0;
  logic                rst_ni      = 1'b0;
  logic                psel        = 1'b0;
  logic                penable     = 1'b0;
  logic                pwrite      = 1'b0;
  logic [PADDR_W-1:0]  paddr       = '0;
  apb_data_t           pwdata      = '0;
  apb_data_t           prdata;
  logic                pready;
  logic                src_valid_i = 1'b0;
  logic                src_ready_o;
  src_byte_t           src_byte_i  = '0;
  logic                out_valid_o;
  logic                out_ready_i = 1'b1;
  pix_addr_t           pixel_addr_o;
  color_t              pixel_color_o;
  logic                last_of_byte_o;
  logic                last_of_pixmap_o;

  // Register copy and expansion state of the predictor.
  pos_t     cfg_dest_x = '0;
  pos_t     cfg_dest_y = '0;
  pitch_t   cfg_pitch  = SCREEN_WIDTH_RESET;
  cnt_t     cfg_pix_w  = '0;
  cnt_t     cfg_pix_h  = '0;
  color_t   cfg_fg     = FG_COLOR_RESET;
  color_t   cfg_bg     = '0;
  cnt_t     col_pos    = '0;
  cnt_t     row_pos    = '0;
  fb_addr_t line_base  = '0;

  pixel_write_t pending_writes[$];

  int unsigned n_errors  = 0;
  int unsigned n_bytes   = 0;
  int unsigned n_writes  = 0;
  int unsigned n_pixmaps = 0;
  bit          calm      = 1'b0;

  mono_color_expand_blit u_dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready),
    .src_valid_i      (src_valid_i),
    .src_ready_o      (src_ready_o),
    .src_byte_i       (src_byte_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .pixel_addr_o     (pixel_addr_o),
    .pixel_color_o    (pixel_color_o),
    .last_of_byte_o   (last_of_byte_o),
    .last_of_pixmap_o (last_of_pixmap_o)
  );

  initial begin
    forever #(CLK_PERIOD / 2) clk_i = ~clk_i;
  end

  initial begin
    #(RUN_LIMIT_NS);
    $display("Run did not finish in time, %0d writes still pending.", pending_writes.size());
    $display("CHECK FAILED");
    $finish;
  end

  // Works out the pixel writes that one source byte causes.
  function automatic void expand_byte(src_byte_t data);
    logic [31:0]  origin;
    int unsigned  left;
    int unsigned  n;
    int           k;
    pixel_write_t w;
    if (cfg_pix_w == '0 || cfg_pix_h == '0) begin
      col_pos = '0;
      row_pos = '0;
      return;
    end
    // A geometry that shrank below the current position restarts the pixmap.
    if (col_pos >= cfg_pix_w || row_pos >= cfg_pix_h) begin
      col_pos = '0;
      row_pos = '0;
    end
    if (col_pos == '0 && row_pos == '0) begin
      origin    = 32'(cfg_dest_y) * 32'(cfg_pitch) + 32'(cfg_dest_x);
      line_base = origin[FB_ADDR_BITS-1:0];
    end
    left = 32'(cfg_pix_w) - 32'(col_pos);
    n    = (left < BITS_PER_SOURCE_BYTE) ? left : BITS_PER_SOURCE_BYTE;
    for (k = 0; k < n; k++) begin
      w.addr        = pix_addr_t'(line_base + fb_addr_t'(col_pos));
      w.color       = data[7-k] ? cfg_fg : cfg_bg;
      w.last_byte   = (k == n - 1);
      w.last_pixmap = 1'b0;
      col_pos       = col_pos + 1'b1;
      if (col_pos >= cfg_pix_w) begin
        col_pos   = '0;
        row_pos   = row_pos + 1'b1;
        line_base = line_base + fb_addr_t'(cfg_pitch);
        if (row_pos >= cfg_pix_h) begin
          row_pos       = '0;
          w.last_pixmap = 1'b1;
        end
      end
      pending_writes.push_back(w);
    end
  endfunction

  // Mostly short gaps, now and then a long one, none while calm is set.
  function automatic int unsigned pick_gap();
    int unsigned r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic int unsigned rand_coord();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r == 0) return 0;
    if (r == 1) return 4095;
    return $urandom_range(0, 4095);
  endfunction

  function automatic int unsigned rand_pitch();
    int unsigned r;
    r = $urandom_range(0, 19);
    if (r == 0) return 0;
    if (r == 1) return 1;
    if (r == 2) return 8191;
    if (r == 3) return 4096;
    return $urandom_range(1, 4096);
  endfunction

  function automatic byte_q_t random_bytes(int unsigned n);
    byte_q_t q;
    repeat (n) q.push_back(src_byte_t'($urandom_range(0, 255)));
    return q;
  endfunction

  task automatic report_mismatch(string what, int unsigned got, int unsigned want);
    n_errors++;
    $display("%0t: %s mismatch, got 0x%0h, expected 0x%0h", $time, what, got, want);
  endtask

  always @(posedge clk_i) begin : pixel_check
    pixel_write_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      n_writes++;
      if (pending_writes.size() == 0) begin
        report_mismatch("unexpected pixel write, addr", 32'(pixel_addr_o), 0);
      end else begin
        want = pending_writes.pop_front();
        if (pixel_addr_o !== want.addr)
          report_mismatch("pixel_addr", 32'(pixel_addr_o), 32'(want.addr));
        if (pixel_color_o !== want.color)
          report_mismatch("pixel_color", 32'(pixel_color_o), 32'(want.color));
        if (last_of_byte_o !== want.last_byte)
          report_mismatch("last_of_byte", 32'(last_of_byte_o), 32'(want.last_byte));
        if (last_of_pixmap_o !== want.last_pixmap)
          report_mismatch("last_of_pixmap", 32'(last_of_pixmap_o), 32'(want.last_pixmap));
        if (want.last_pixmap) n_pixmaps++;
      end
    end
  end

  // Sink side: random back-pressure on the pixel output.
  initial begin : sink_stall
    int unsigned hold;
    forever begin
      @(posedge clk_i);
      hold = pick_gap();
      if (hold != 0) begin
        out_ready_i <= 1'b0;
        repeat (hold) @(posedge clk_i);
        out_ready_i <= 1'b1;
      end
      repeat ($urandom_range(0, 6)) @(posedge clk_i);
    end
  end

  // One APB write: setup, access, then the bus returns to idle.
  task automatic write_reg(reg_idx_e idx, int unsigned value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_DEST_X:       cfg_dest_x = pos_t'(value);
      REG_DEST_Y:       cfg_dest_y = pos_t'(value);
      REG_SCREEN_WIDTH: cfg_pitch  = pitch_t'(value);
      REG_PIX_WIDTH:    cfg_pix_w  = cnt_t'(value);
      REG_PIX_HEIGHT:   cfg_pix_h  = cnt_t'(value);
      REG_FG_COLOR:     cfg_fg     = color_t'(value);
      REG_BG_COLOR:     cfg_bg     = color_t'(value);
      default: ;
    endcase
    @(posedge clk_i);
  endtask

  // Waits for every predicted write, then lets a byte that gave none finish.
  task automatic wait_quiet();
    while (pending_writes.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic program_blit(int unsigned dx, int unsigned dy, int unsigned pitch,
                              int unsigned pw, int unsigned ph,
                              int unsigned fg, int unsigned bg);
    wait_quiet();
    write_reg(REG_DEST_X, dx);
    write_reg(REG_DEST_Y, dy);
    write_reg(REG_SCREEN_WIDTH, pitch);
    write_reg(REG_PIX_WIDTH, pw);
    write_reg(REG_PIX_HEIGHT, ph);
    write_reg(REG_FG_COLOR, fg);
    write_reg(REG_BG_COLOR, bg);
  endtask

  // Sends source bytes in order. Valid stays high between back-to-back words
  // and drops after the last one.
  task automatic send_bytes(byte_q_t bytes);
    int unsigned gap;
    foreach (bytes[i]) begin
      src_valid_i <= 1'b1;
      src_byte_i  <= bytes[i];
      do @(posedge clk_i); while (!src_ready_o);
      expand_byte(bytes[i]);
      n_bytes++;
      gap = pick_gap();
      if (gap != 0 || i == bytes.size() - 1) begin
        src_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
  endtask

  // Right after reset the pixmap is empty; only the size is then set.
  task automatic test_reset_state();
    send_bytes('{8'hFF, 8'h00});
    wait_quiet();
    write_reg(REG_PIX_WIDTH, 3);
    write_reg(REG_PIX_HEIGHT, 2);
    send_bytes('{8'hA0, 8'h5F});
  endtask

  // A row that ends inside the second byte.
  task automatic test_partial_rows();
    program_blit(5, 7, 100, 11, 2, 'h3C, 'hC3);
    send_bytes('{8'hFF, 8'hE0, 8'h00, 8'h1F});
  endtask

  task automatic test_address_extremes();
    program_blit(4095, 4095, 8191, 16, 2, 'h00, 'hFF);
    send_bytes('{8'h00, 8'hFF, 8'h81, 8'h7E});
    program_blit(4095, 0, 4096, 65535, 65535, 'hAA, 'h55);
    send_bytes('{8'hF0, 8'h0F});
  endtask

  // With a pitch of zero every row lands on the same line.
  task automatic test_zero_pitch();
    program_blit(17, 3, 0, 9, 3, 'h12, 'hED);
    send_bytes('{8'h80, 8'h80, 8'h7F, 8'h00, 8'hC3, 8'hFF});
  endtask

  task automatic test_empty_pixmap();
    program_blit(0, 0, 320, 0, 4, 'hFF, 'h00);
    send_bytes('{8'hFF, 8'h55});
    program_blit(0, 0, 320, 4, 0, 'hFF, 'h00);
    send_bytes('{8'hAA, 8'h01});
    wait_quiet();
    write_reg(REG_PIX_HEIGHT, 1);
    send_bytes('{8'h90});
  endtask

  // Geometry and color writes while a pixmap is only partly sent.
  task automatic test_geometry_changes();
    program_blit(10, 20, 64, 16, 4, 'h11, 'h22);
    send_bytes('{8'hC0, 8'h03, 8'h5A});
    wait_quiet();
    write_reg(REG_PIX_WIDTH, 8);
    send_bytes('{8'hE7});
    wait_quiet();
    write_reg(REG_FG_COLOR, 'h99);
    write_reg(REG_DEST_X, 300);
    write_reg(REG_SCREEN_WIDTH, 1000);
    send_bytes('{8'h3C});
    wait_quiet();
    write_reg(REG_PIX_HEIGHT, 2);
    send_bytes('{8'h81});
  endtask

  task automatic test_random_pixmaps();
    int unsigned counted;
    int unsigned kind;
    int unsigned pw;
    int unsigned ph;
    int unsigned total;
    int unsigned first;
    counted = 0;
    while (counted < RANDOM_BYTES) begin
      calm = ($urandom_range(0, 5) == 0);
      kind = $urandom_range(0, 99);
      pw   = $urandom_range(1, 24);
      ph   = $urandom_range(1, 5);
      if (kind < 5) begin
        // Noise: bytes into an empty pixmap are dropped.
        if ($urandom_range(0, 1)) pw = 0;
        else ph = 0;
        program_blit(rand_coord(), rand_coord(), rand_pitch(), pw, ph,
                     $urandom_range(0, 255), $urandom_range(0, 255));
        send_bytes(random_bytes($urandom_range(1, 3)));
        continue;
      end
      if (kind >= 94) begin
        pw = $urandom_range(0, 1) ? 65535 : $urandom_range(200, 4000);
        ph = $urandom_range(0, 1) ? 65535 : $urandom_range(1, 8);
      end else if (kind >= 80 && $urandom_range(0, 3) == 0) begin
        ph = 65535;
      end
      program_blit(rand_coord(), rand_coord(), rand_pitch(), pw, ph,
                   $urandom_range(0, 255), $urandom_range(0, 255));
      total = ((pw + 7) / 8) * ph;
      if (kind >= 94) begin
        total = $urandom_range(1, 6);
        send_bytes(random_bytes(total));
      end else if (kind >= 80 && total > 1) begin
        // Broken pixmap: the next setup starts over or carries on from here.
        total = $urandom_range(1, (total > 30) ? 30 : total - 1);
        send_bytes(random_bytes(total));
      end else if (kind >= 70 && total > 1) begin
        first = total / 2;
        send_bytes(random_bytes(first));
        wait_quiet();
        write_reg(REG_FG_COLOR, $urandom_range(0, 255));
        write_reg(REG_BG_COLOR, $urandom_range(0, 255));
        if ($urandom_range(0, 1)) write_reg(REG_SCREEN_WIDTH, rand_pitch());
        if ($urandom_range(0, 1)) write_reg(REG_DEST_X, rand_coord());
        send_bytes(random_bytes(total - first));
      end else begin
        send_bytes(random_bytes(total));
      end
      counted += total;
    end
    calm = 1'b0;
  endtask

  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_state();
    test_partial_rows();
    test_address_extremes();
    test_zero_pitch();
    test_empty_pixmap();
    test_geometry_changes();
    test_random_pixmaps();
    wait_quiet();
    $display("Sent %0d source bytes and compared %0d pixel writes, %0d pixmaps completed.",
             n_bytes, n_writes, n_pixmaps);
    $display("Included empty and shrunk pixmaps, zero pitch, address wrap and mid-pixmap writes.");
    if (n_errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
